// ----- design/sdtq_pkg.sv -----
package sdtq_pkg;

  localparam int SLOTS     = 16;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int BURST_MAX = 16;
  localparam int K_W       = $clog2(BURST_MAX);

  localparam int IN_W  = 96;
  localparam int OUT_W = 72;

  typedef enum logic [1:0] {
    ACT_SET     = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_SERVICE = 2'd2,
    ACT_QUERY   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DELAY = 2'd1,
    ST_FULL      = 2'd2
  } stat_code_t;

  typedef enum logic {
    CFG_DELAY_LIMIT  = 1'b0,
    CFG_EARLY_MARGIN = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_CHECK,
    S_SEEK,
    S_PLACE,
    S_EMIT,
    S_SVC,
    S_SVC_EMIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       idx_inc;
    logic       hit;
    logic       remove;
    logic       seek_done;
    logic       insert;
    logic       set_res;
    stat_code_t code;
    logic       pop;
    logic       emit;
  } ctl_cmd_t;

  typedef struct packed {
    action_t action;
    logic    hit;
    logic    idx_end;
    logic    bad_delay;
    logic    found;
    logic    full;
    logic    precedes;
    logic    fire;
    logic    k_zero;
    logic    res_last;
    logic    out_free;
  } dp_stat_t;

  function automatic logic passed(input logic [31:0] now, input logic [31:0] t);
    logic [31:0] d;
    d = now - t;
    return ~d[31];
  endfunction

  function automatic logic fires(input logic [31:0] now, input logic [31:0] dl,
                                 input logic [15:0] margin);
    return passed(now, dl - {16'd0, margin}) | passed(now, dl);
  endfunction

endpackage

// ----- design/sdtq_ctrl.sv -----
module sdtq_ctrl
  import sdtq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = ST_OK;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        if (stat.action == ACT_SERVICE) begin
          state_next = S_SVC;
        end else if (stat.hit) begin
          cmd.hit    = 1'b1;
          state_next = S_CHECK;
        end else if (stat.idx_end) begin
          state_next = S_CHECK;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_CHECK: begin
        cmd.set_res = 1'b1;
        state_next  = S_EMIT;
        case (stat.action)
          ACT_SET: begin
            if (stat.bad_delay) begin
              cmd.code = ST_BAD_DELAY;
            end else if (!stat.found && stat.full) begin
              cmd.code = ST_FULL;
            end else begin
              cmd.remove = 1'b1;
              state_next = S_SEEK;
            end
          end
          ACT_CLEAR: cmd.remove = 1'b1;
          default: ;
        endcase
      end
      S_SEEK: begin
        if (stat.idx_end || stat.precedes) begin
          cmd.seek_done = 1'b1;
          state_next    = S_PLACE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_PLACE: begin
        cmd.insert = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SVC: begin
        if (stat.fire) begin
          cmd.pop    = 1'b1;
          state_next = S_SVC_EMIT;
        end else if (stat.k_zero) begin
          cmd.set_res = 1'b1;
          state_next  = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SVC_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.res_last ? S_IDLE : S_SVC;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- design/sdtq_dp.sv -----
module sdtq_dp
  import sdtq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ctl_cmd_t         cmd,
  output dp_stat_t         stat,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic [1:0]       s_tuser,
  input  logic             cfg_valid,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);

  action_t     act;
  logic [15:0] key_msg, key_task, margin;
  logic [31:0] dly, now_r, limit;

  logic [15:0] e_msg  [SLOTS];
  logic [15:0] e_task [SLOTS];
  logic [31:0] e_dl   [SLOTS];

  logic [CNT_W-1:0] count, idx_cnt;
  logic [IDX_W-1:0] pos, ins_pos, rpos;
  logic [K_W-1:0]   k;
  logic             found;

  stat_code_t  res_status;
  logic        res_expired, res_found, res_event, res_last;
  logic [15:0] res_msg, res_task;

  logic [IDX_W-1:0] idx;
  logic [31:0]      new_dl, head_dl;
  logic             in_range, do_remove, pop_last, head_valid;

  assign idx       = idx_cnt[IDX_W-1:0];
  assign new_dl    = now_r + dly;
  assign in_range  = idx_cnt < count;
  assign rpos      = cmd.pop ? '0 : pos;
  assign do_remove = cmd.pop | (cmd.remove & found);
  assign pop_last  = (k == K_W'(BURST_MAX - 1)) || (count <= CNT_W'(1)) ||
                     !fires(now_r, e_dl[1], margin);
  assign head_valid = count != '0;
  assign head_dl    = head_valid ? e_dl[0] : 32'd0;

  always_comb begin
    stat           = '0;
    stat.action    = act;
    stat.hit       = in_range && e_msg[idx] == key_msg && e_task[idx] == key_task;
    stat.idx_end   = !in_range;
    stat.bad_delay = dly == 32'd0 || dly >= limit;
    stat.found     = found;
    stat.full      = count == CNT_W'(SLOTS);
    stat.precedes  = in_range && ((new_dl - e_dl[idx]) > limit);
    stat.fire      = head_valid && fires(now_r, e_dl[0], margin);
    stat.k_zero    = k == '0;
    stat.res_last  = res_last;
    stat.out_free  = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit  <= 32'h7FFF_FFFF;
      margin <= 16'd50;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DELAY_LIMIT:  limit  <= cfg_data;
        CFG_EARLY_MARGIN: margin <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx_cnt  <= '0;
      found    <= 1'b0;
      k        <= '0;
      m_tvalid <= 1'b0;
      act      <= ACT_SET;
    end else begin
      if (cmd.load) begin
        act      <= action_t'(s_tuser);
        key_msg  <= s_tdata[15:0];
        key_task <= s_tdata[31:16];
        dly      <= s_tdata[63:32];
        now_r    <= s_tdata[95:64];
        idx_cnt  <= '0;
        found    <= 1'b0;
        k        <= '0;
      end
      if (cmd.idx_inc) idx_cnt <= idx_cnt + CNT_W'(1);
      if (cmd.hit) begin
        found <= 1'b1;
        pos   <= idx;
      end
      if (cmd.remove) idx_cnt <= '0;
      if (cmd.seek_done) ins_pos <= idx;

      if (do_remove) begin
        for (int i = 0; i < SLOTS - 1; i++) begin
          if (IDX_W'(i) >= rpos) begin
            e_msg[i]  <= e_msg[i+1];
            e_task[i] <= e_task[i+1];
            e_dl[i]   <= e_dl[i+1];
          end
        end
        count <= count - CNT_W'(1);
      end
      if (cmd.insert) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (IDX_W'(i) == ins_pos) begin
            e_msg[i]  <= key_msg;
            e_task[i] <= key_task;
            e_dl[i]   <= new_dl;
          end
        end
        for (int i = 1; i < SLOTS; i++) begin
          if (IDX_W'(i) > ins_pos) begin
            e_msg[i]  <= e_msg[i-1];
            e_task[i] <= e_task[i-1];
            e_dl[i]   <= e_dl[i-1];
          end
        end
        count     <= count + CNT_W'(1);
        res_event <= passed(now_r, new_dl);
      end

      if (cmd.set_res) begin
        res_status  <= cmd.code;
        res_expired <= 1'b0;
        res_msg     <= '0;
        res_task    <= '0;
        res_found   <= found && (cmd.code == ST_OK);
        res_event   <= 1'b0;
        res_last    <= 1'b1;
      end
      if (cmd.pop) begin
        res_status  <= ST_OK;
        res_expired <= 1'b1;
        res_msg     <= e_msg[0];
        res_task    <= e_task[0];
        res_found   <= 1'b0;
        res_event   <= 1'b0;
        res_last    <= pop_last;
        k           <= k + K_W'(1);
      end

      if (cmd.emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {2'b00, res_event, head_dl, head_valid, res_found,
                     res_task, res_msg, res_expired, res_status};
        m_tlast  <= res_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/sorted_deadline_timer_queue_top.sv -----
// Set walks the table at most twice (key walk, then insert walk); clear and query walk
// it once; service gives one word per fired timer, or a single word when none fires.
// Throughput: one word at a time; set, clear and query walk the table one slot per cycle.
// Reset (rst, synchronous): table empty, delay_limit 0x7FFFFFFF, early_margin 50,
// no word pending on the output.
module sorted_deadline_timer_queue_top
  import sdtq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // msg_id, task_id, delay, now
  input  logic [1:0]       s_tuser,  // action
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // status, expired, expired_msg_id, expired_task_id,
                                     // found, deadline_valid, deadline, event_raised
  output logic             m_tlast,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  sdtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sdtq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- design/sdtq_checker.sv -----
module sdtq_checker
  import sdtq_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_empty_dl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[36] |-> m_tdata[68:37] == 32'd0)
    else $error("deadline nonzero with empty table");

  a_fired: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1:0] == ST_OK && !m_tdata[35] && !m_tdata[69])
    else $error("fired word carries set or lookup flags");

  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tlast)
    else $error("non-fired word without last");

endmodule

bind sorted_deadline_timer_queue_top sdtq_checker u_sdtq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- tb/timer_queue_checker.sv -----
`timescale 1ns / 100ps

module timer_queue_checker
  import sdtq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic [1:0]       s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  input  logic             m_tlast,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  output int               mismatches,
  output int               outstanding
);

  typedef struct {
    stat_code_t  status;
    bit          expired;
    bit [15:0]   emsg;
    bit [15:0]   etask;
    bit          found;
    bit          dl_valid;
    bit [31:0]   deadline;
    bit          raised;
    bit          last;
  } timer_result_t;

  timer_result_t due_results[$];

  bit [31:0] limit_reg;
  bit [15:0] margin_reg;
  int        timer_count;
  bit [15:0] tab_msg [SLOTS];
  bit [15:0] tab_task[SLOTS];
  bit [31:0] tab_dl  [SLOTS];

  assign outstanding = due_results.size();

  function automatic bit elapsed(bit [31:0] now, bit [31:0] t);
    bit [31:0] d;
    d = now - t;
    return !d[31];
  endfunction

  function automatic int lookup(bit [15:0] msg, bit [15:0] tsk);
    for (int i = 0; i < timer_count; i++)
      if (tab_msg[i] == msg && tab_task[i] == tsk) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int pos);
    if (pos < 0 || pos >= timer_count) return;
    for (int i = pos; i + 1 < timer_count; i++) begin
      tab_msg[i]  = tab_msg[i+1];
      tab_task[i] = tab_task[i+1];
      tab_dl[i]   = tab_dl[i+1];
    end
    timer_count--;
  endfunction

  function automatic void place_sorted(bit [15:0] msg, bit [15:0] tsk, bit [31:0] dl);
    int pos;
    bit [31:0] diff;
    pos = timer_count;
    for (int i = 0; i < timer_count; i++) begin
      diff = dl - tab_dl[i];
      if (diff > limit_reg) begin
        pos = i;
        break;
      end
    end
    for (int i = timer_count; i > pos; i--) begin
      tab_msg[i]  = tab_msg[i-1];
      tab_task[i] = tab_task[i-1];
      tab_dl[i]   = tab_dl[i-1];
    end
    tab_msg[pos]  = msg;
    tab_task[pos] = tsk;
    tab_dl[pos]   = dl;
    timer_count++;
  endfunction

  function automatic void queue_result(stat_code_t st, bit exp_bit, bit [15:0] emsg,
                                       bit [15:0] etask, bit fnd, bit raised, bit last);
    timer_result_t r;
    r.status   = st;
    r.expired  = exp_bit;
    r.emsg     = emsg;
    r.etask    = etask;
    r.found    = fnd;
    r.dl_valid = timer_count > 0;
    r.deadline = timer_count > 0 ? tab_dl[0] : 32'd0;
    r.raised   = raised;
    r.last     = last;
    due_results.push_back(r);
  endfunction

  function automatic void predict_word(action_t act, bit [15:0] msg, bit [15:0] tsk,
                                       bit [31:0] delay, bit [31:0] now);
    int pos;
    int fired;
    bit [31:0] dl;
    case (act)
      ACT_SET: begin
        if (delay == 0 || delay >= limit_reg) begin
          queue_result(ST_BAD_DELAY, 0, 0, 0, 0, 0, 1);
          return;
        end
        pos = lookup(msg, tsk);
        if (pos < 0 && timer_count >= SLOTS) begin
          queue_result(ST_FULL, 0, 0, 0, 0, 0, 1);
          return;
        end
        drop_slot(pos);
        dl = now + delay;
        place_sorted(msg, tsk, dl);
        queue_result(ST_OK, 0, 0, 0, pos >= 0, elapsed(now, dl), 1);
      end
      ACT_CLEAR, ACT_QUERY: begin
        pos = lookup(msg, tsk);
        if (act == ACT_CLEAR) drop_slot(pos);
        queue_result(ST_OK, 0, 0, 0, pos >= 0, 0, 1);
      end
      default: begin
        fired = 0;
        while (fired < BURST_MAX && timer_count > 0) begin
          dl = tab_dl[0];
          if (!elapsed(now, dl - {16'd0, margin_reg}) && !elapsed(now, dl)) break;
          msg = tab_msg[0];
          tsk = tab_task[0];
          drop_slot(0);
          queue_result(ST_OK, 1, msg, tsk, 0, 0, 0);
          fired++;
        end
        if (fired == 0) queue_result(ST_OK, 0, 0, 0, 0, 0, 1);
        else due_results[$].last = 1;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, longint got, longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    timer_result_t w;
    if (rst) begin
      limit_reg   = 32'h7FFF_FFFF;
      margin_reg  = 16'd50;
      timer_count = 0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DELAY_LIMIT) limit_reg = cfg_data;
        else margin_reg = cfg_data[15:0];
      end
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected word", m_tdata[63:0], 0);
        end else begin
          w = due_results.pop_front();
          check_field("status", m_tdata[1:0], w.status);
          check_field("expired", m_tdata[2], w.expired);
          check_field("expired_msg_id", m_tdata[18:3], w.emsg);
          check_field("expired_task_id", m_tdata[34:19], w.etask);
          check_field("found", m_tdata[35], w.found);
          check_field("deadline_valid", m_tdata[36], w.dl_valid);
          check_field("deadline", m_tdata[68:37], w.deadline);
          check_field("event_raised", m_tdata[69], w.raised);
          check_field("last", m_tlast, w.last);
        end
      end
      if (s_tvalid && s_tready)
        predict_word(action_t'(s_tuser), s_tdata[15:0], s_tdata[31:16],
                     s_tdata[63:32], s_tdata[95:64]);
    end
  end

endmodule

// ----- tb/sorted_deadline_timer_queue_top_test.sv -----
`timescale 1ns / 100ps

module sorted_deadline_timer_queue_top_test
  import sdtq_pkg::*;
;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 2 * SLOTS + 10;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic [1:0]       s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [31:0]      cfg_data;

  int        mismatches;
  int        outstanding;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_left;
  bit        hold_go;
  bit        hold_seen;
  int        idle_cycles;
  int        words_in;
  int        words_out;
  bit [31:0] tick;
  bit [31:0] cur_limit;

  sorted_deadline_timer_queue_top dut (.*);

  timer_queue_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_go && !hold_seen) begin
      hold_seen <= 1;
      hold_left <= 400;
      m_tready  <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 0;
    end else begin
      m_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
      words_in    <= 0;
      words_out   <= 0;
    end else begin
      if (s_tvalid && s_tready) words_in <= words_in + 1;
      if (m_tvalid && m_tready) words_out <= words_out + 1;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(action_t act, bit [15:0] msg, bit [15:0] tsk,
                           bit [31:0] delay, bit [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= act;
    s_tdata  <= {now, delay, tsk, msg};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, bit [31:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_regs(bit [31:0] lim, bit [15:0] margin);
    write_reg(CFG_DELAY_LIMIT, lim);
    write_reg(CFG_EARLY_MARGIN, {16'd0, margin});
    cur_limit = lim;
  endtask

  task automatic random_words(int n);
    int        pick;
    action_t   act;
    bit [15:0] msg;
    bit [15:0] tsk;
    bit [31:0] delay;
    bit [31:0] now;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      act = pick < 45 ? ACT_SET : pick < 70 ? ACT_SERVICE : pick < 85 ? ACT_CLEAR : ACT_QUERY;
      if ($urandom_range(99) < 75) begin
        msg = 16'($urandom_range(5));
        tsk = 16'($urandom_range(2));
      end else begin
        msg = 16'($urandom);
        tsk = 16'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 70) delay = $urandom_range(2000, 1);
      else if (pick < 80) delay = 0;
      else if (pick < 90) delay = cur_limit - $urandom_range(1, 0);
      else delay = $urandom;
      tick = tick + $urandom_range(300);
      now = $urandom_range(99) < 10 ? $urandom : tick;
      send_word(act, msg, tsk, delay, now);
    end
  endtask

  initial begin
    rst            = 1;
    s_tvalid       = 0;
    s_tdata        = '0;
    s_tuser        = ACT_SET;
    cfg_valid      = 0;
    cfg_index      = CFG_DELAY_LIMIT;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 0;
    tick           = 32'd1000;
    cur_limit      = 32'h7FFF_FFFF;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_word(ACT_QUERY, 0, 0, 0, 1000);
    send_word(ACT_SET, 0, 0, 0, 1000);
    send_word(ACT_SET, 0, 0, 32'h7FFF_FFFF, 1000);
    send_word(ACT_SET, 0, 0, 32'hFFFF_FFFF, 1000);
    send_word(ACT_SET, 0, 0, 1, 1000);
    send_word(ACT_SET, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
    send_word(ACT_SET, 0, 0, 500, 1000);
    send_word(ACT_QUERY, 0, 0, 0, 1000);
    send_word(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 0, 1000);
    send_word(ACT_SERVICE, 0, 0, 0, 1000);
    send_word(ACT_SERVICE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1460);
    for (int i = 0; i < SLOTS; i++)
      send_word(ACT_SET, i[15:0], 16'h00A5, 100 + i, 2000);
    send_word(ACT_SET, 16'h1234, 16'h5678, 10, 2000);
    send_word(ACT_SET, 16'd3, 16'h00A5, 5, 2000);
    send_word(ACT_SERVICE, 0, 0, 0, 9000);
    random_words(20);
    drain();

    set_regs(32'hFFFF_FFFF, 16'hFFFF);
    send_idle_pct = 65;
    send_word(ACT_SET, 16'h00FF, 16'hFF00, 32'h8000_0000, tick);
    random_words(30);
    drain();

    set_regs(32'd1000, 16'd0);
    send_idle_pct = 0;
    recv_stall_pct = 65;
    random_words(30);
    drain();

    set_regs(32'd1, 16'd300);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    random_words(15);
    drain();

    set_regs(32'h7FFF_FFFF, 16'd50);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go <= 1;
    random_words(30);
    drain();

    $display("sent %0d words, received %0d words across five register settings",
             words_in, words_out);
    $display("covered bad delay, full table, replace, clear, query, service bursts, stalls");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/sdtq_pkg.sv
design/sdtq_ctrl.sv
design/sdtq_dp.sv
design/sorted_deadline_timer_queue_top.sv
design/sdtq_checker.sv
tb/timer_queue_checker.sv
tb/sorted_deadline_timer_queue_top_test.sv
